/* src/spt_pkg.sv */
// stroke point thinner: shared types, register indexes, reset values
// compass direction and corner helpers used by the decision logic
// no dependencies
package spt_pkg;

    localparam int unsigned COUNT_BITS  = 16;
    localparam int unsigned NEAR_BITS   = 8;
    localparam int unsigned PERIOD_BITS = 4;
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS = 16;
    localparam int unsigned PERIOD_MAX  = 15;

    localparam logic [NEAR_BITS-1:0]   NEAR_LIMIT_RST    = 8'd3;
    localparam logic [COUNT_BITS-1:0]  BYPASS_LENGTH_RST = 16'd30;
    localparam logic [PERIOD_BITS-1:0] KEEP_PERIOD_RST   = 4'd3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NEAR_LIMIT    = 2'd0,
        CFG_BYPASS_LENGTH = 2'd1,
        CFG_KEEP_PERIOD   = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [NEAR_BITS-1:0]   near_limit;
        logic [COUNT_BITS-1:0]  bypass_length;
        logic [PERIOD_BITS-1:0] keep_period;
    } t_cfg;

    // order of first against second coordinate
    typedef enum logic [1:0] {
        ORD_LT = 2'd0,
        ORD_EQ = 2'd1,
        ORD_GT = 2'd2
    } t_order;

    // ring of eight compass codes plus none
    typedef logic [3:0] t_dir;
    localparam t_dir DIR_L    = 4'd0;
    localparam t_dir DIR_LB   = 4'd1;
    localparam t_dir DIR_B    = 4'd2;
    localparam t_dir DIR_RB   = 4'd3;
    localparam t_dir DIR_R    = 4'd4;
    localparam t_dir DIR_RT   = 4'd5;
    localparam t_dir DIR_T    = 4'd6;
    localparam t_dir DIR_LT   = 4'd7;
    localparam t_dir DIR_NONE = 4'd8;

    typedef struct packed {
        logic hit_index;   // index is a multiple of the keep period
        logic first;       // index zero
        logic second;      // index one
        logic last;        // final point of the stroke
    } t_index_info;

    typedef struct packed {
        logic keep;
        logic first;
        logic last;
    } t_decision;

    function automatic t_dir dir_code(input t_order ox, input t_order oy);
        t_dir d;
        d = DIR_NONE;
        case (ox)
            ORD_LT: begin
                case (oy)
                    ORD_LT:  d = DIR_RT;
                    ORD_EQ:  d = DIR_R;
                    default: d = DIR_RB;
                endcase
            end
            ORD_EQ: begin
                case (oy)
                    ORD_LT:  d = DIR_T;
                    ORD_EQ:  d = DIR_NONE;
                    default: d = DIR_B;
                endcase
            end
            default: begin
                case (oy)
                    ORD_LT:  d = DIR_LT;
                    ORD_EQ:  d = DIR_L;
                    default: d = DIR_LB;
                endcase
            end
        endcase
        return d;
    endfunction

    // true when the two directions differ by more than one compass step, or when only one is none
    function automatic logic is_corner(input t_dir d1, input t_dir d2);
        logic [2:0] diff;
        logic       c;
        diff = d1[2:0] - d2[2:0];
        if (d1 == d2) begin
            c = 1'b0;
        end else if (d1 == DIR_NONE || d2 == DIR_NONE) begin
            c = 1'b1;
        end else begin
            c = !(diff == 3'd1 || diff == 3'd7);
        end
        return c;
    endfunction

endpackage

/* src/spt_mod_lanes.sv */
// stroke point thinner: one phase counter per possible keep period
// uses spt_pkg for widths
module spt_mod_lanes (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic                             i_restart,
    input  logic [spt_pkg::PERIOD_BITS-1:0]  i_period,
    output logic                             o_hit
);

    // lane k holds the current index modulo k
    logic [spt_pkg::PERIOD_BITS-1:0] r_phase [1:spt_pkg::PERIOD_MAX];

    genvar k;
    generate
        for (k = 1; k <= spt_pkg::PERIOD_MAX; k++) begin : g_lane
            logic [spt_pkg::PERIOD_BITS-1:0] n_phase;
            always_comb begin
                if (i_restart || r_phase[k] == spt_pkg::PERIOD_BITS'(k - 1)) begin
                    n_phase = '0;
                end else begin
                    n_phase = r_phase[k] + 1'b1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_phase[k] <= '0;
                end else if (i_step) begin
                    r_phase[k] <= n_phase;
                end
            end
        end
    endgenerate

    always_comb begin
        if (i_period == '0) begin
            o_hit = 1'b0;
        end else begin
            o_hit = (r_phase[i_period] == '0);
        end
    end

endmodule

/* src/spt_decide.sv */
// stroke point thinner: keep or drop decision for one point
// uses spt_pkg for config, direction and decision types
module spt_decide #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0]    i_x,
    input  logic signed [COORD_BITS-1:0]    i_y,
    input  logic signed [COORD_BITS-1:0]    i_prev_x,
    input  logic signed [COORD_BITS-1:0]    i_prev_y,
    input  logic signed [COORD_BITS-1:0]    i_last_x,
    input  logic signed [COORD_BITS-1:0]    i_last_y,
    input  logic signed [COORD_BITS-1:0]    i_older_x,
    input  logic signed [COORD_BITS-1:0]    i_older_y,
    input  logic                            i_bypass,
    input  spt_pkg::t_index_info            i_index,
    input  spt_pkg::t_cfg                   i_cfg,
    output spt_pkg::t_decision              o_decision
);

    localparam int unsigned DIFF_BITS = COORD_BITS + 1;

    logic signed [DIFF_BITS-1:0] dx;
    logic signed [DIFF_BITS-1:0] dy;
    logic [DIFF_BITS-1:0]        mag_x;
    logic [DIFF_BITS-1:0]        mag_y;
    logic [DIFF_BITS-1:0]        near_ext;
    logic                        far;
    spt_pkg::t_dir               dir_in;
    spt_pkg::t_dir               dir_kept;
    logic                        corner;

    function automatic spt_pkg::t_order order3(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        spt_pkg::t_order o;
        if (a < b) begin
            o = spt_pkg::ORD_LT;
        end else if (a == b) begin
            o = spt_pkg::ORD_EQ;
        end else begin
            o = spt_pkg::ORD_GT;
        end
        return o;
    endfunction

    always_comb begin
        dx       = DIFF_BITS'(i_x) - DIFF_BITS'(i_last_x);
        dy       = DIFF_BITS'(i_y) - DIFF_BITS'(i_last_y);
        mag_x    = dx[DIFF_BITS-1] ? unsigned'(-dx) : unsigned'(dx);
        mag_y    = dy[DIFF_BITS-1] ? unsigned'(-dy) : unsigned'(dy);
        near_ext = DIFF_BITS'(i_cfg.near_limit);
        far      = (mag_x >= near_ext) || (mag_y >= near_ext);

        dir_in   = spt_pkg::dir_code(order3(i_prev_x, i_x), order3(i_prev_y, i_y));
        dir_kept = spt_pkg::dir_code(order3(i_older_x, i_last_x),
                                     order3(i_older_y, i_last_y));
        corner   = spt_pkg::is_corner(dir_in, dir_kept);

        o_decision.keep  = i_bypass || i_index.first || i_index.second || i_index.last
                         || far || corner || i_index.hit_index;
        o_decision.first = i_index.first;
        o_decision.last  = i_index.last;
    end

endmodule

/* src/stroke_point_thinner_unit.sv */
// stroke point thinner: top level with state, config registers and result register
// uses spt_pkg, spt_mod_lanes and spt_decide
//
// takes one stroke point per beat and emits zero or one kept point per beat. every
// point carries the stroke's total point count; strokes no longer than bypass_length
// pass unchanged, otherwise the first two points and the last are always kept and a
// middle point is dropped only when it sits within near_limit of the last kept point
// on both axes, does not turn more than one compass step against the last kept
// segment, and its index is not a multiple of keep_period. an input beat's result is in
// the output register in the next cycle, and a new point is taken every cycle unless the
// output stalls: the whole decision is compares and a small direction table between the
// state registers and the result register. a dropped point produces no output beat.
// in ready follows the output side: a point is taken when the result register is
// empty or being drained in the same cycle. config writes are accepted whenever out of
// reset and should only be made with no points in flight.
module stroke_point_thinner_unit #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // point input
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [COORD_BITS-1:0]         i_point_x,
    input  logic signed [COORD_BITS-1:0]         i_point_y,
    input  logic [spt_pkg::COUNT_BITS-1:0]       i_stroke_points,
    // kept point output
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [COORD_BITS-1:0]         o_kept_x,
    output logic signed [COORD_BITS-1:0]         o_kept_y,
    output logic                                 o_starts_stroke,
    output logic                                 o_ends_stroke,
    // register writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [spt_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [spt_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    // configuration
    spt_pkg::t_cfg r_cfg;

    // stroke state
    logic [spt_pkg::COUNT_BITS-1:0]  r_index;
    logic signed [COORD_BITS-1:0]    r_prev_x;
    logic signed [COORD_BITS-1:0]    r_prev_y;
    logic signed [COORD_BITS-1:0]    r_last_x;
    logic signed [COORD_BITS-1:0]    r_last_y;
    logic signed [COORD_BITS-1:0]    r_older_x;
    logic signed [COORD_BITS-1:0]    r_older_y;

    // result register
    logic                            r_out_valid;
    logic signed [COORD_BITS-1:0]    r_kept_x;
    logic signed [COORD_BITS-1:0]    r_kept_y;
    logic                            r_starts;
    logic                            r_ends;

    logic                            accept;
    logic [spt_pkg::COUNT_BITS-1:0]  count;
    logic [spt_pkg::COUNT_BITS:0]    index_plus;
    logic                            bypass;
    logic                            hit_index;
    spt_pkg::t_index_info            index_info;
    spt_pkg::t_decision              decision;
    logic [spt_pkg::COUNT_BITS-1:0]  n_index;

    assign o_in_ready  = i_rst_n && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = i_rst_n;

    // zero stroke length counts as one point
    assign count      = (i_stroke_points == '0) ? spt_pkg::COUNT_BITS'(1) : i_stroke_points;
    assign index_plus = {1'b0, r_index} + 1'b1;
    assign bypass     = (count <= r_cfg.bypass_length);

    always_comb begin
        index_info.hit_index = hit_index;
        index_info.first     = (r_index == '0);
        index_info.second    = (r_index == spt_pkg::COUNT_BITS'(1));
        index_info.last      = (index_plus >= {1'b0, count});
        n_index = index_info.last ? '0 : index_plus[spt_pkg::COUNT_BITS-1:0];
    end

    spt_mod_lanes u_lanes (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (accept),
        .i_restart (index_info.last),
        .i_period  (r_cfg.keep_period),
        .o_hit     (hit_index)
    );

    spt_decide #(
        .COORD_BITS (COORD_BITS)
    ) u_decide (
        .i_x        (i_point_x),
        .i_y        (i_point_y),
        .i_prev_x   (r_prev_x),
        .i_prev_y   (r_prev_y),
        .i_last_x   (r_last_x),
        .i_last_y   (r_last_y),
        .i_older_x  (r_older_x),
        .i_older_y  (r_older_y),
        .i_bypass   (bypass),
        .i_index    (index_info),
        .i_cfg      (r_cfg),
        .o_decision (decision)
    );

    // register writes; an index past the list is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_limit    <= spt_pkg::NEAR_LIMIT_RST;
            r_cfg.bypass_length <= spt_pkg::BYPASS_LENGTH_RST;
            r_cfg.keep_period   <= spt_pkg::KEEP_PERIOD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                spt_pkg::CFG_NEAR_LIMIT: begin
                    r_cfg.near_limit <= i_cfg_data[spt_pkg::NEAR_BITS-1:0];
                end
                spt_pkg::CFG_BYPASS_LENGTH: begin
                    r_cfg.bypass_length <= i_cfg_data[spt_pkg::COUNT_BITS-1:0];
                end
                spt_pkg::CFG_KEEP_PERIOD: begin
                    r_cfg.keep_period <= i_cfg_data[spt_pkg::PERIOD_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // stroke state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_older_x   <= '0;
            r_older_y   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_index  <= n_index;
                r_prev_x <= i_point_x;
                r_prev_y <= i_point_y;
                if (decision.keep) begin
                    r_older_x <= r_last_x;
                    r_older_y <= r_last_y;
                    r_last_x  <= i_point_x;
                    r_last_y  <= i_point_y;
                end
                r_out_valid <= decision.keep;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only for a kept point
    always_ff @(posedge i_clk) begin
        if (accept && decision.keep) begin
            r_kept_x <= i_point_x;
            r_kept_y <= i_point_y;
            r_starts <= decision.first;
            r_ends   <= decision.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kept_x        = r_kept_x;
    assign o_kept_y        = r_kept_y;
    assign o_starts_stroke = r_starts;
    assign o_ends_stroke   = r_ends;

endmodule

/* src/spt_checker.sv */
// stroke point thinner: port-level checks over time, bound to the top level
// uses spt_pkg for port widths
module spt_checker #(
    parameter int unsigned COORD_BITS = 16
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic signed [COORD_BITS-1:0]         i_point_x,
    input logic signed [COORD_BITS-1:0]         i_point_y,
    input logic [spt_pkg::COUNT_BITS-1:0]       i_stroke_points,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [COORD_BITS-1:0]         o_kept_x,
    input logic signed [COORD_BITS-1:0]         o_kept_y,
    input logic                                 o_starts_stroke,
    input logic                                 o_ends_stroke
);

    // a stalled output beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kept_x)
            && $stable(o_kept_y) && $stable(o_starts_stroke) && $stable(o_ends_stroke))
        else $error("output beat changed while stalled");

    // nothing shows on the output straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // an empty result register never back-pressures the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // a one-point stroke is always kept and closes its stroke
    a_single_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_stroke_points == spt_pkg::COUNT_BITS'(1)
        |=> o_out_valid && o_ends_stroke && o_kept_x == $past(i_point_x)
            && o_kept_y == $past(i_point_y))
        else $error("one-point stroke not passed through");

endmodule

bind stroke_point_thinner_unit spt_checker #(
    .COORD_BITS (COORD_BITS)
) u_spt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_point_x       (i_point_x),
    .i_point_y       (i_point_y),
    .i_stroke_points (i_stroke_points),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_kept_x        (o_kept_x),
    .o_kept_y        (o_kept_y),
    .o_starts_stroke (o_starts_stroke),
    .o_ends_stroke   (o_ends_stroke)
);

/* bench/tb_stroke_point_thinner_unit.sv */
// self-checking bench for stroke_point_thinner_unit: random and directed strokes
// against a cycle-free model of the thinning rules; depends on spt_pkg and the dut
`timescale 1ns / 100ps

module tb_stroke_point_thinner_unit;

    localparam int unsigned COORD_BITS = 16;
    localparam int STALL_LIMIT   = 4000;  // cycles with no beat on any channel
    localparam int SETTLE_CYCLES = 4;     // result register is loaded in the cycle after an input beat
    localparam int PRINT_CAP     = 60;
    localparam logic [spt_pkg::CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 2'd3;  // no register here

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct {
        t_coord                         x;
        t_coord                         y;
        logic [spt_pkg::COUNT_BITS-1:0] count;
    } t_stroke_pt;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   is_first;
        logic   is_last;
    } t_kept_pt;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // point side
    logic                           in_valid  = 1'b0;
    logic                           o_in_ready;
    t_coord                         drv_x     = '0;
    t_coord                         drv_y     = '0;
    logic [spt_pkg::COUNT_BITS-1:0] drv_count = '0;

    // kept point side
    logic   o_out_valid;
    logic   out_ready = 1'b0;
    t_coord o_kept_x;
    t_coord o_kept_y;
    logic   o_starts_stroke;
    logic   o_ends_stroke;

    // register writes
    logic                              cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [spt_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [spt_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;

    stroke_point_thinner_unit #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_point_x       (drv_x),
        .i_point_y       (drv_y),
        .i_stroke_points (drv_count),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_kept_x        (o_kept_x),
        .o_kept_y        (o_kept_y),
        .o_starts_stroke (o_starts_stroke),
        .o_ends_stroke   (o_ends_stroke),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // points waiting to be driven, and kept points still owed by the dut
    t_stroke_pt point_fifo[$];
    t_kept_pt   kept_fifo[$];

    int mismatches  = 0;
    int cycle_count = 0;
    int stall_count = 0;
    int phase_items = 0;

    // shadow of the register file, only touched while the dut is idle
    logic [spt_pkg::NEAR_BITS-1:0]   near_cfg   = spt_pkg::NEAR_LIMIT_RST;
    logic [spt_pkg::COUNT_BITS-1:0]  bypass_cfg = spt_pkg::BYPASS_LENGTH_RST;
    logic [spt_pkg::PERIOD_BITS-1:0] period_cfg = spt_pkg::KEEP_PERIOD_RST;

    // shadow of the thinning state
    logic [spt_pkg::COUNT_BITS-1:0] idx_now = '0;
    t_coord prev_x  = '0;
    t_coord prev_y  = '0;
    t_coord last_x  = '0;
    t_coord last_y  = '0;
    t_coord older_x = '0;
    t_coord older_y = '0;

    task automatic log_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // random idling, switched off in alternate windows of cycle_count to run at full rate
    function automatic logic take_break();
        if ((cycle_count % 2000) >= 1000)
            return 1'b0;
        return ($urandom_range(0, 99) < 29);
    endfunction

    // compass heading of the step from (x1,y1) to (x2,y2)
    function automatic spt_pkg::t_dir heading(input t_coord x1, input t_coord y1,
                                              input t_coord x2, input t_coord y2);
        if (x1 < x2) begin
            if (y1 < y2)       return spt_pkg::DIR_RT;
            else if (y1 == y2) return spt_pkg::DIR_R;
            else               return spt_pkg::DIR_RB;
        end else if (x1 == x2) begin
            if (y1 < y2)       return spt_pkg::DIR_T;
            else if (y1 == y2) return spt_pkg::DIR_NONE;
            else               return spt_pkg::DIR_B;
        end else begin
            if (y1 < y2)       return spt_pkg::DIR_LT;
            else if (y1 == y2) return spt_pkg::DIR_L;
            else               return spt_pkg::DIR_LB;
        end
    endfunction

    // more than one compass step apart; a standstill only matches a standstill
    function automatic logic sharp_turn(input spt_pkg::t_dir a, input spt_pkg::t_dir b);
        int step;
        if (a == b)
            return 1'b0;
        if (a == spt_pkg::DIR_NONE || b == spt_pkg::DIR_NONE)
            return 1'b1;
        step = (int'(a) - int'(b)) & 7;
        return !(step == 1 || step == 7);
    endfunction

    // decide one accepted point and queue the kept point it owes, if any
    function automatic void thin_point(input t_coord x, input t_coord y,
                                       input logic [spt_pkg::COUNT_BITS-1:0] count);
        int       span;
        int       i;
        int       ax;
        int       ay;
        logic     last;
        logic     keep;
        t_kept_pt k;
        span = (count == 0) ? 1 : int'(count);
        i    = int'(idx_now);
        last = (i + 1 >= span);
        ax   = int'(x) - int'(last_x);
        ay   = int'(y) - int'(last_y);
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;

        if (span <= int'(bypass_cfg) || i <= 1 || last)
            keep = 1'b1;
        else if (ax >= int'(near_cfg) || ay >= int'(near_cfg))
            keep = 1'b1;
        else if (sharp_turn(heading(prev_x, prev_y, x, y),
                            heading(older_x, older_y, last_x, last_y)))
            keep = 1'b1;
        else if (period_cfg != 0 && (i % int'(period_cfg)) == 0)
            keep = 1'b1;
        else
            keep = 1'b0;

        prev_x  = x;
        prev_y  = y;
        idx_now = last ? '0 : spt_pkg::COUNT_BITS'(i + 1);

        if (keep) begin
            older_x    = last_x;
            older_y    = last_y;
            last_x     = x;
            last_y     = y;
            k.x        = x;
            k.y        = y;
            k.is_first = (i == 0);
            k.is_last  = last;
            kept_fifo  = {kept_fifo, k};
        end
    endfunction

    // point driver: a beat is taken on valid and ready, the next one is put up
    // straight away unless this cycle is an idle one
    always @(posedge i_clk) begin
        t_stroke_pt p;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready)
                thin_point(drv_x, drv_y, drv_count);
            if (!in_valid || o_in_ready) begin
                if (point_fifo.size() != 0 && !take_break()) begin
                    p = point_fifo.pop_front();
                    drv_x     <= p.x;
                    drv_y     <= p.y;
                    drv_count <= p.count;
                    in_valid  <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // kept point monitor: every beat is checked against the oldest owed point
    always @(posedge i_clk) begin
        t_kept_pt want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (kept_fifo.size() == 0) begin
                    log_mismatch($sformatf("kept point x=%0d y=%0d with none owed",
                                           o_kept_x, o_kept_y));
                end else begin
                    want = kept_fifo.pop_front();
                    if (o_kept_x !== want.x)
                        log_mismatch($sformatf("kept_x %0d, want %0d", o_kept_x, want.x));
                    if (o_kept_y !== want.y)
                        log_mismatch($sformatf("kept_y %0d, want %0d", o_kept_y, want.y));
                    if (o_starts_stroke !== want.is_first)
                        log_mismatch($sformatf("starts_stroke %0b, want %0b at x=%0d",
                                               o_starts_stroke, want.is_first, want.x));
                    if (o_ends_stroke !== want.is_last)
                        log_mismatch($sformatf("ends_stroke %0b, want %0b at x=%0d",
                                               o_ends_stroke, want.is_last, want.x));
                end
            end
            out_ready <= !take_break();
        end
    end

    // watchdog on cycles where no channel moves a beat
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("[%0t] no beat for %0d cycles", $realtime, STALL_LIMIT);
                $display("tb_stroke_point_thinner_unit failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [spt_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [spt_pkg::CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        // the register keeps only its low bits
        case (idx)
            spt_pkg::CFG_NEAR_LIMIT:    near_cfg   = data[spt_pkg::NEAR_BITS-1:0];
            spt_pkg::CFG_BYPASS_LENGTH: bypass_cfg = data[spt_pkg::COUNT_BITS-1:0];
            spt_pkg::CFG_KEEP_PERIOD:   period_cfg = data[spt_pkg::PERIOD_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic push_point(input t_coord x, input t_coord y,
                              input logic [spt_pkg::COUNT_BITS-1:0] count);
        t_stroke_pt p;
        p.x        = x;
        p.y        = y;
        p.count    = count;
        point_fifo = {point_fifo, p};
        phase_items++;
    endtask

    // one stroke as a random walk: mostly short steps that hold their heading,
    // now and then a turn or a jump; a broken stroke may carry a wrong count
    task automatic add_stroke(input logic broken);
        int n;
        int sx;
        int sy;
        t_coord x;
        t_coord y;
        logic [spt_pkg::COUNT_BITS-1:0] count;
        n  = ($urandom_range(0, 29) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 40);
        x  = t_coord'($urandom);
        y  = t_coord'($urandom);
        sx = int'($urandom_range(0, 6)) - 3;
        sy = int'($urandom_range(0, 6)) - 3;
        for (int k = 0; k < n; k++) begin
            count = spt_pkg::COUNT_BITS'(n);
            if (broken) begin
                case ($urandom_range(0, 3))
                    0:       count = spt_pkg::COUNT_BITS'($urandom);
                    1:       count = '0;
                    2:       count = spt_pkg::COUNT_BITS'(n + int'($urandom_range(0, 4)) - 2);
                    default: count = spt_pkg::COUNT_BITS'(n);
                endcase
            end
            push_point(x, y, count);
            if ($urandom_range(0, 19) == 0) begin
                x = t_coord'($urandom);
                y = t_coord'($urandom);
            end else begin
                if ($urandom_range(0, 9) < 3) begin
                    sx = int'($urandom_range(0, 6)) - 3;
                    sy = int'($urandom_range(0, 6)) - 3;
                end
                x = t_coord'(x + sx);
                y = t_coord'(y + sy);
            end
        end
    endtask

    // wait until every point is in and every kept point is out, then let the
    // result register settle before anything touches the registers; sampled on
    // the falling edge so the driver's updates at the rising edge have landed
    task automatic drain();
        while (point_fifo.size() != 0 || in_valid || kept_fifo.size() != 0 || o_out_valid)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_strokes(input int target);
        phase_items = 0;
        while (phase_items < target)
            add_stroke($urandom_range(0, 99) < 15);
        drain();
    endtask

    task automatic random_setup();
        write_reg(spt_pkg::CFG_NEAR_LIMIT,    {8'($urandom), 8'($urandom_range(1, 12))});
        write_reg(spt_pkg::CFG_BYPASS_LENGTH, 16'($urandom_range(0, 8)));
        write_reg(spt_pkg::CFG_KEEP_PERIOD,   {12'($urandom), 4'($urandom_range(0, 15))});
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at their reset values, strokes either side of the bypass length
        run_strokes(200);

        // directed: tight near limit, bypass only up to two points, period five
        write_reg(spt_pkg::CFG_NEAR_LIMIT, 16'd4);
        write_reg(spt_pkg::CFG_BYPASS_LENGTH, 16'd2);
        write_reg(spt_pkg::CFG_KEEP_PERIOD, 16'd5);
        phase_items = 0;
        // zero stroke length counts as one, coordinate extremes
        push_point(16'sh7FFF, -16'sh8000, 16'd0);
        push_point(-16'sh8000, 16'sh7FFF, 16'd1);
        // a stroke that exercises dropping, turns, standstill and the period
        push_point(0, 0, 16'd12);
        push_point(1, 0, 16'd12);
        push_point(2, 0, 16'd12);
        push_point(3, 1, 16'd12);
        push_point(3, 3, 16'd12);
        push_point(3, 3, 16'd12);
        push_point(3, 3, 16'd12);
        push_point(10, 3, 16'd12);
        push_point(11, 3, 16'd12);
        push_point(12, 4, 16'd12);
        push_point(13, 4, 16'd12);
        push_point(14, 4, 16'd12);
        // count shrinks below the index: taken as the last point
        push_point(-1, -1, 16'd5);
        push_point(0, 0, 16'd5);
        push_point(1, 1, 16'd5);
        push_point(2, 1, 16'd2);
        // longest count, left open, then closed by a one-point count
        push_point(-1, -1, 16'hFFFF);
        push_point(0, -1, 16'd1);
        drain();

        // zero near limit, no bypass, no period: everything is kept
        write_reg(spt_pkg::CFG_NEAR_LIMIT, 16'h0000);
        write_reg(spt_pkg::CFG_BYPASS_LENGTH, 16'h0000);
        write_reg(spt_pkg::CFG_KEEP_PERIOD, 16'h0000);
        run_strokes(150);

        // widest near limit and longest period: heavy thinning
        write_reg(spt_pkg::CFG_NEAR_LIMIT, 16'hFFFF);
        write_reg(spt_pkg::CFG_KEEP_PERIOD, 16'h000F);
        run_strokes(150);

        // longest bypass: every stroke passes
        write_reg(spt_pkg::CFG_NEAR_LIMIT, 16'h00FF);
        write_reg(spt_pkg::CFG_BYPASS_LENGTH, 16'hFFFF);
        write_reg(spt_pkg::CFG_KEEP_PERIOD, 16'hFFF1);
        run_strokes(150);

        random_setup();
        run_strokes(150);

        // a write to the unused index must leave the registers alone
        random_setup();
        write_reg(CFG_IDX_SPARE, 16'($urandom));
        run_strokes(150);

        random_setup();
        run_strokes(150);

        random_setup();
        run_strokes(150);

        if (kept_fifo.size() != 0)
            log_mismatch($sformatf("%0d kept points never came", kept_fifo.size()));
        if (mismatches == 0) begin
            $display("tb_stroke_point_thinner_unit passed");
        end else begin
            $display("tb_stroke_point_thinner_unit failed");
        end
        $finish;
    end

endmodule
